### hdl/bslp_pkg.sv
package bslp_pkg;

	localparam int CntW     = 8;
	localparam int BtnW     = 4;
	localparam int FlagW    = 2 * BtnW;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 8;

	// request codes
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_LONG     = 1'b1;

	// reset values of the registers
	localparam logic [CntW-1:0] DEBOUNCE_RST = 8'd3;
	localparam logic [CntW-1:0] LONG_RST     = 8'd100;

	typedef struct packed {
		logic [CntW-1:0] debounce_ticks;
		logic [CntW-1:0] long_press_ticks;
	} bslp_cfg_t;

	// priority pick: right, left, down, up; lines are active low
	function automatic logic [BtnW-1:0] pick_button(input logic [BtnW-1:0] pins);
		logic [BtnW-1:0] low;
		logic [BtnW-1:0] btn;
		low = ~pins;
		btn = '0;
		if (low[3]) begin
			btn = 4'b1000;
		end else if (low[2]) begin
			btn = 4'b0100;
		end else if (low[1]) begin
			btn = 4'b0010;
		end else if (low[0]) begin
			btn = 4'b0001;
		end
		return btn;
	endfunction

endpackage

### hdl/bslp_cfg.sv
module bslp_cfg
	import bslp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output bslp_cfg_t           cfg
);

	logic [CntW-1:0] debounce_q;
	logic [CntW-1:0] long_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_wdata[CntW-1:0];
				REG_LONG:     long_q     <= cfg_wdata[CntW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.debounce_ticks   = debounce_q;
	assign cfg.long_press_ticks = long_q;

endmodule

### hdl/bslp_core.sv
module bslp_core
	import bslp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  bslp_cfg_t        cfg,
	input  logic             en,
	input  logic             req_type,
	input  logic [BtnW-1:0]  pins,
	output logic [FlagW-1:0] result
);

	logic [CntW-1:0]  lock_q;
	logic [CntW-1:0]  hold_q;
	logic             latched_q;
	logic [BtnW-1:0]  last_q;
	logic [FlagW-1:0] flags_q;

	logic [CntW-1:0]  lock_d;
	logic [CntW-1:0]  hold_d;
	logic             latched_d;
	logic [BtnW-1:0]  last_d;
	logic [FlagW-1:0] flags_d;
	logic [BtnW-1:0]  btn;
	logic [CntW-1:0]  hold_inc;

	assign btn      = pick_button(pins);
	assign hold_inc = hold_q + 1'b1;

	// next state for one item
	always_comb begin
		lock_d    = lock_q;
		hold_d    = hold_q;
		latched_d = latched_q;
		last_d    = last_q;
		flags_d   = flags_q;
		result    = flags_q;
		if (req_type == REQ_READ) begin
			flags_d = '0;
		end else begin
			if (btn != '0) begin
				if (lock_q < cfg.debounce_ticks) begin
					lock_d = lock_q + 1'b1;
				end else begin
					last_d    = btn;
					latched_d = 1'b1;
					if (hold_q < cfg.long_press_ticks) begin
						hold_d = hold_inc;
						// long flag once the hold reaches the limit
						if (hold_inc >= cfg.long_press_ticks) begin
							flags_d = flags_q | {btn, {BtnW{1'b0}}};
						end
					end
				end
			end else begin
				if (lock_q != '0) begin
					lock_d = lock_q - 1'b1;
				end else if (latched_q) begin
					latched_d = 1'b0;
					hold_d    = '0;
					// short flag when released before the long limit
					if (hold_q < cfg.long_press_ticks) begin
						flags_d = flags_q | {{BtnW{1'b0}}, last_q};
					end
				end
			end
			result = flags_d;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q    <= '0;
			hold_q    <= '0;
			latched_q <= 1'b0;
			last_q    <= '0;
			flags_q   <= '0;
		end else if (en) begin
			lock_q    <= lock_d;
			hold_q    <= hold_d;
			latched_q <= latched_d;
			last_q    <= last_d;
			flags_q   <= flags_d;
		end
	end

endmodule

### hdl/button_short_long_press_detector.sv
// channel  | handshake            | payload
// input    | in_valid, in_stall   | req_type, pin_levels
// output   | out_valid, out_stall | press_flags
// config   | cfg_we               | cfg_index, cfg_wdata
//
// one item per cycle sustained while the output is not stalled; a taken item
// passes the input register, then the state update and the result register,
// before its result shows on the output
// asynchronous reset clears state, flags and valids; registers go to 3 and 100
// an output stall holds the result register and backs up into the input
// register; in_stall rises only while both are full

module button_short_long_press_detector
	import bslp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [BtnW-1:0]     pin_levels,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FlagW-1:0]    press_flags,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	bslp_cfg_t        cfg;
	logic             valid_s1;
	logic             req_s1;
	logic [BtnW-1:0]  pins_s1;
	logic             valid_s2;
	logic [FlagW-1:0] flags_s2;
	logic [FlagW-1:0] result;
	logic             adv;
	logic             take;

	// stage 1 moves on when the result register is free or being emptied
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	bslp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bslp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.en       (adv),
		.req_type (req_s1),
		.pins     (pins_s1),
		.result   (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || adv) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1  <= req_type;
			pins_s1 <= pin_levels;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv || !out_stall) begin
			valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign press_flags = flags_s2;

endmodule

### hdl/bslp_chk.sv
module bslp_chk
	import bslp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [FlagW-1:0] press_flags
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(press_flags))
		else $error("stalled result changed");

	// an empty result register never backs up the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// out_valid is checked high after every item taken has passed the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing after item");

	// input stall only comes with a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stall without output stall");

endmodule

bind button_short_long_press_detector bslp_chk u_bslp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.press_flags (press_flags)
);
